[hdl/tpd_pkg.sv]
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants for the touch pad detector
// Field widths, register codes, the control FSM encoding and the divider
// request/response bundles.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int unsigned PadW      = 3;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned RangeW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned NumW      = 21;  // (delta - thr) * 25
  localparam int unsigned DenW      = 32;  // thr * range
  localparam int unsigned QuotW     = 18;  // quotient bits below 2^18
  localparam int unsigned LevelW    = 17;  // UQ1.16
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 24;

  localparam logic [CfgDataW-1:0] ThreshReset  = 64'h0064_0064_0064_0064;
  localparam logic [RangeW-1:0]   RangeReset   = 16'd200;
  localparam logic [RangeW-1:0]   RangeDefault = 16'd100;
  // 100 * 2^16 = 25 * 2^18: the numerator is (delta - thr) * 25 shifted by QuotW
  localparam logic [4:0]          DeltaScale   = 5'd25;
  localparam logic [LevelW-1:0]   LevelOne     = 17'h10000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THR_LO = 2'd0,
    CFG_THR_HI = 2'd1,
    CFG_RANGE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/tpd_cfg.sv]
// ----------------------------------------------------------------------------
// tpd_cfg: configuration registers
// Holds the packed per-pad thresholds and the pressure range; returns the
// threshold of one pad and the effective range.
// ----------------------------------------------------------------------------
module tpd_cfg import tpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [PadW-1:0]     pad_i,
  output logic [ThrW-1:0]     thr_o,
  output logic [RangeW-1:0]   range_o
);

  logic [CfgDataW-1:0] thr_lo_q, thr_hi_q;
  logic [RangeW-1:0]   range_q;
  logic [CfgDataW-1:0] thr_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lo_q <= ThreshReset;
      thr_hi_q <= ThreshReset;
      range_q  <= RangeReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_THR_LO: thr_lo_q <= cfg_data_i;
        CFG_THR_HI: thr_hi_q <= cfg_data_i;
        CFG_RANGE:  range_q  <= cfg_data_i[RangeW-1:0];
        default: ;
      endcase
    end
  end

  assign thr_word = pad_i[2] ? thr_hi_q : thr_lo_q;
  assign thr_o    = thr_word[{pad_i[1:0], 4'b0000} +: ThrW];
  // zero range acts as 100 percent
  assign range_o  = (range_q == '0) ? RangeDefault : range_q;

endmodule

[hdl/tpd_div.sv]
// ----------------------------------------------------------------------------
// tpd_div: bit-serial restoring divider
// One quotient bit per cycle. Caller guarantees
// num < den so the quotient fits in QuotW bits.
// ----------------------------------------------------------------------------
module tpd_div import tpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [DenW:0]    rem_q, rem_d, rem_shift;
  logic [DenW-1:0]  den_q;
  logic [QuotW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic             fits;

  // remainder stays below den, so the doubled value fits in DenW+1 bits
  assign rem_shift = {rem_q[DenW-1:0], 1'b0};
  assign fits      = rem_shift >= {1'b0, den_q};
  assign rem_d     = fits ? (rem_shift - {1'b0, den_q}) : rem_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= (DenW + 1)'(req_i.num);
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[QuotW-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[hdl/touch_pad_detect_pressure.sv]
// ----------------------------------------------------------------------------
// touch_pad_detect_pressure: capacitive touch detection with pressure level
// Per sample: delta = |raw - baseline|, touching when delta >= threshold,
// per-pad touch flag with change report, UQ1.16 pressure while touching.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+---------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | pad_index, raw, baseline
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | pad, flags, pressure_level
//  cfg       | in  | cfg_valid_i / cfg_ready_o      | register index, 64b data
//
//  Flow: a touching item with a nonzero threshold below the saturation point
//    is accepted, multiplied, checked, divided by the bit-serial divider, and
//    its quotient is taken, then it moves to the output register; saturated
//    items skip the divider, and idle pads go straight to the output register.
//  Reset: all touch flags clear, thresholds 100, range 200, no item pending.
//  Stalls: one item in flight; the output register holds a finished item
//    while the next one is accepted and worked on. Config is always ready.
//
module touch_pad_detect_pressure import tpd_pkg::*; #(
  parameter int unsigned PAD_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] pad_index, [18:3] raw_count, [34:19] baseline_count, [39:35] zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [2:0] pad_number, [3] is_touching, [4] touch_changed,
  // [5] pressure_valid, [22:6] pressure_level, [23] zero
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  state_e state_q, state_d;

  // input unpack
  logic [PadW-1:0]   pad_in;
  logic [CountW-1:0] raw_in, base_in, delta_in;
  logic [ThrW-1:0]   thr_in;
  logic [RangeW-1:0] range_eff;
  logic              touch_in, pad_ok, accept, cur_flag;

  // item payload
  logic [PadW-1:0]   pad_q;
  logic              touch_q, chg_q;
  logic [CountW-1:0] delta_q;
  logic [ThrW-1:0]   thr_q;
  logic [NumW-1:0]   n25_q, n25_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [CountW-1:0] excess;
  logic [LevelW-1:0] level_q, level_d;

  logic [PAD_COUNT-1:0] touch_flags_q;

  logic                 out_valid_q, load_out;
  logic [OutTdataW-1:0] out_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pad_in   = s_axis_tdata[2:0];
  assign raw_in   = s_axis_tdata[18:3];
  assign base_in  = s_axis_tdata[34:19];
  assign delta_in = (raw_in >= base_in) ? (raw_in - base_in) : (base_in - raw_in);
  assign touch_in = delta_in >= thr_in;
  assign pad_ok   = {1'b0, pad_in} < 4'(PAD_COUNT);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  tpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pad_i       (pad_in),
    .thr_o       (thr_in),
    .range_o     (range_eff)
  );

  // stored flag of the addressed pad
  always_comb begin
    cur_flag = 1'b0;
    for (int k = 0; k < PAD_COUNT; k++) begin
      if (pad_in == PadW'(k)) cur_flag = touch_flags_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_flags_q <= '0;
    end else if (accept && pad_ok) begin
      for (int k = 0; k < PAD_COUNT; k++) begin
        if (pad_in == PadW'(k)) touch_flags_q[k] <= touch_in;
      end
    end
  end

  // numerator scaled so the quotient needs QuotW bits; denominator thr * range
  assign excess = delta_q - thr_q;
  assign n25_d  = NumW'(excess) * NumW'(DeltaScale);
  assign den_d  = DenW'(thr_q) * DenW'(range_eff);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pad_q   <= pad_in;
      touch_q <= touch_in;
      chg_q   <= touch_in ^ cur_flag;
      delta_q <= delta_in;
      thr_q   <= thr_in;
    end
    if (state_q == ST_MUL) begin
      n25_q <= n25_d;
      den_q <= den_d;
    end
    level_q <= level_d;
    if (load_out) out_data_q <= {1'b0, level_q, touch_q, chg_q, touch_q, pad_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    state_d       = state_q;
    level_d       = level_q;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = n25_q;
    div_req.den   = den_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && pad_ok) begin
          level_d = '0;
          // zero threshold or no touch: level stays zero
          state_d = (touch_in && (thr_in != '0)) ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: state_d = ST_CHK;
      ST_CHK: begin
        if ((DenW'(n25_q)) >= den_q) begin
          // quotient would reach 2^18: far past full scale
          level_d = LevelOne;
          state_d = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          level_d = (div_rsp.quot > {1'b0, LevelOne}) ? LevelOne
                                                      : div_rsp.quot[LevelW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  tpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[22:6] <= LevelOne))
    else $error("pressure level above full scale");

  a_idle_no_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[3]) |-> (m_axis_tdata[22:6] == '0))
    else $error("pressure reported for a pad that is not touching");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_ready_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_rsp.busy)
    else $error("input ready while divider busy");

endmodule
